/* design/nal_bit_reader_exp_golomb_assert.svh */
// Assertion macros shared by the bit reader modules.
`ifndef NAL_BIT_READER_EXP_GOLOMB_ASSERT_SVH
`define NAL_BIT_READER_EXP_GOLOMB_ASSERT_SVH

// Whenever ante holds, cons must hold in the same cycle.
`define NBR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Whenever ante holds, cons must hold in the cycle after.
`define NBR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// cond must hold at every clock edge out of reset.
`define NBR_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    `NBR_ASSERT_IMPL(label, clk, rst_n, 1'b1, cond, msg)

`endif

/* design/nbr_pkg.sv */
// Shared constants, command codes and control/status types of the bit reader.
package nbr_pkg;

    localparam int BUF_BYTES = 4096;
    localparam int ADDR_W    = $clog2(BUF_BYTES);
    localparam int CNT_W     = $clog2(BUF_BYTES + 1);
    localparam int ZEROS_W   = 6;
    localparam int BL_W      = (CNT_W + 3 > 16) ? CNT_W + 3 : 16;

    localparam logic [2:0] CMD_APPEND = 3'd0;
    localparam logic [2:0] CMD_NEWBUF = 3'd1;
    localparam logic [2:0] CMD_GET    = 3'd2;
    localparam logic [2:0] CMD_SHOW   = 3'd3;
    localparam logic [2:0] CMD_SKIP   = 3'd4;
    localparam logic [2:0] CMD_UE     = 3'd5;
    localparam logic [2:0] CMD_SE     = 3'd6;

    localparam logic [15:0]        MAX_GET      = 16'd32;
    localparam logic [ZEROS_W-1:0] GOLOMB_LIMIT = 6'd32;
    localparam logic [7:0]         ESC_BYTE     = 8'h03;
    localparam logic [2:0]         BIT_MSB      = 3'd7;

    typedef struct packed {
        logic load_req;
        logic do_append;
        logic do_newbuf;
        logic start;
        logic set_err;
        logic mem_rd;
        logic take_bit;
        logic esc_chk;
        logic finish;
    } nbr_ctl_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic       cnt_over;
        logic       at_end;
        logic       cur_valid;
        logic       loop_done;
        logic       esc_pending;
    } nbr_sts_t;

endpackage

/* design/nbr_if.sv */
// Request and result channel interfaces of the bit reader.
interface nbr_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [7:0]  data_byte;
    logic [15:0] bit_count;

    modport source (output valid, output command, output data_byte, output bit_count,
                    input ready);
    modport sink (input valid, input command, input data_byte, input bit_count,
                  output ready);
endinterface

interface nbr_out_if;
    logic               valid;
    logic               ready;
    logic [31:0]        value;
    logic signed [32:0] signed_value;
    logic               read_error;
    logic [15:0]        bits_left;

    modport source (output valid, output value, output signed_value, output read_error,
                    output bits_left, input ready);
    modport sink (input valid, input value, input signed_value, input read_error,
                  input bits_left, output ready);
endinterface

/* design/nbr_datapath.sv */
// Datapath of the bit reader: byte store, read position, bit accumulator, result register.
`include "nal_bit_reader_exp_golomb_assert.svh"

module nbr_datapath
    import nbr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  nbr_ctl_t           ctl,
    output nbr_sts_t           sts,
    input  logic [2:0]         command,
    input  logic [7:0]         data_byte,
    input  logic [15:0]        bit_count,
    output logic [31:0]        value,
    output logic signed [32:0] signed_value,
    output logic               read_error,
    output logic [15:0]        bits_left
);

    logic [7:0] mem [BUF_BYTES];
    logic [7:0] rd_data_reg;

    logic [2:0]  cmd_reg, cmd_next;
    logic [7:0]  byte_reg, byte_next;
    logic [15:0] cnt_reg, cnt_next;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic [2:0]       bit_reg, bit_next;
    logic             z1_reg, z1_next;
    logic             esc_reg, esc_next;
    logic             cur_valid_reg, cur_valid_next;

    logic [CNT_W-1:0] save_pos_reg, save_pos_next;
    logic [2:0]       save_bit_reg, save_bit_next;
    logic             save_z1_reg, save_z1_next;

    logic [15:0]        counter_reg, counter_next;
    logic [ZEROS_W-1:0] zeros_reg, zeros_next;
    logic [31:0]        acc_reg, acc_next;
    logic               prefix_reg, prefix_next;
    logic               err_reg, err_next;

    logic [31:0]        value_reg, value_next;
    logic signed [32:0] sval_reg, sval_next;
    logic               rerr_reg, rerr_next;
    logic [15:0]        bl_reg, bl_next;

    logic             full;
    logic             cur_bit;
    logic [CNT_W-1:0] pos_inc;
    logic [CNT_W-1:0] fin_pos;
    logic [2:0]       fin_bit;
    logic [BL_W-1:0]  bl_wide;
    logic [32:0]      half;
    logic             is_golomb;

    assign full      = (count_reg == CNT_W'(BUF_BYTES));
    assign cur_bit   = rd_data_reg[bit_reg];
    assign pos_inc   = pos_reg + 1'b1;
    assign is_golomb = (cmd_reg == CMD_UE) || (cmd_reg == CMD_SE);
    assign half      = {2'b00, acc_reg[31:1]};

    // A show command reports the bits left at the position it started from.
    assign fin_pos = (cmd_reg == CMD_SHOW) ? save_pos_reg : pos_reg;
    assign fin_bit = (cmd_reg == CMD_SHOW) ? save_bit_reg : bit_reg;
    assign bl_wide = (BL_W'(fin_pos < count_reg ? count_reg - fin_pos : '0) << 3)
                   - BL_W'(BIT_MSB - fin_bit);

    always_comb
    begin
        cmd_next       = cmd_reg;
        byte_next      = byte_reg;
        cnt_next       = cnt_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        bit_next       = bit_reg;
        z1_next        = z1_reg;
        esc_next       = esc_reg;
        cur_valid_next = cur_valid_reg;
        save_pos_next  = save_pos_reg;
        save_bit_next  = save_bit_reg;
        save_z1_next   = save_z1_reg;
        counter_next   = counter_reg;
        zeros_next     = zeros_reg;
        acc_next       = acc_reg;
        prefix_next    = prefix_reg;
        err_next       = err_reg;
        value_next     = value_reg;
        sval_next      = sval_reg;
        rerr_next      = rerr_reg;
        bl_next        = bl_reg;

        if (ctl.load_req)
        begin
            cmd_next  = command;
            byte_next = data_byte;
            cnt_next  = bit_count;
            err_next  = 1'b0;
        end

        if (ctl.do_append)
        begin
            if (full)
            begin
                err_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + 1'b1;
            end
        end

        if (ctl.do_newbuf)
        begin
            count_next     = '0;
            pos_next       = '0;
            bit_next       = BIT_MSB;
            z1_next        = 1'b0;
            esc_next       = 1'b0;
            cur_valid_next = 1'b0;
        end

        if (ctl.start)
        begin
            counter_next  = cnt_reg;
            zeros_next    = '0;
            acc_next      = '0;
            prefix_next   = is_golomb;
            save_pos_next = pos_reg;
            save_bit_next = bit_reg;
            save_z1_next  = z1_reg;
        end

        if (ctl.set_err)
        begin
            err_next = 1'b1;
        end

        if (ctl.mem_rd)
        begin
            cur_valid_next = 1'b1;
        end

        if (ctl.take_bit)
        begin
            if (prefix_reg)
            begin
                if (cur_bit)
                begin
                    // The suffix is read into an accumulator seeded with the
                    // leading one, so that the code is simply acc - 1.
                    prefix_next  = 1'b0;
                    acc_next     = 32'd1;
                    counter_next = (zeros_reg == GOLOMB_LIMIT) ? 16'd0 : 16'(zeros_reg);
                end
                else if (zeros_reg != GOLOMB_LIMIT)
                begin
                    zeros_next = zeros_reg + 1'b1;
                end
            end
            else
            begin
                acc_next     = {acc_reg[30:0], cur_bit};
                counter_next = counter_reg - 1'b1;
            end

            if (bit_reg == 3'd0)
            begin
                bit_next       = BIT_MSB;
                pos_next       = pos_inc;
                cur_valid_next = 1'b0;
                z1_next        = (rd_data_reg == 8'd0);
                esc_next       = z1_reg && (rd_data_reg == 8'd0) && (pos_inc < count_reg);
            end
            else
            begin
                bit_next = bit_reg - 1'b1;
            end
        end

        if (ctl.esc_chk)
        begin
            esc_next = 1'b0;
            if (rd_data_reg == ESC_BYTE)
            begin
                pos_next       = pos_reg + 1'b1;
                z1_next        = 1'b0;
                cur_valid_next = 1'b0;
            end
        end

        if (ctl.finish)
        begin
            value_next = '0;
            sval_next  = '0;
            if (!err_reg)
            begin
                if ((cmd_reg == CMD_GET) || (cmd_reg == CMD_SHOW))
                begin
                    value_next = acc_reg;
                end
                else if (is_golomb)
                begin
                    value_next = acc_reg - 1'b1;
                    sval_next  = acc_reg[0] ? -$signed(half) : $signed(half);
                end
            end
            rerr_next = err_reg;
            bl_next   = bl_wide[15:0];
            if (cmd_reg == CMD_SHOW)
            begin
                pos_next       = save_pos_reg;
                bit_next       = save_bit_reg;
                z1_next        = save_z1_reg;
                cur_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            pos_reg       <= '0;
            bit_reg       <= BIT_MSB;
            z1_reg        <= 1'b0;
            esc_reg       <= 1'b0;
            cur_valid_reg <= 1'b0;
            prefix_reg    <= 1'b0;
            err_reg       <= 1'b0;
            counter_reg   <= '0;
        end
        else
        begin
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            bit_reg       <= bit_next;
            z1_reg        <= z1_next;
            esc_reg       <= esc_next;
            cur_valid_reg <= cur_valid_next;
            prefix_reg    <= prefix_next;
            err_reg       <= err_next;
            counter_reg   <= counter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        byte_reg     <= byte_next;
        cnt_reg      <= cnt_next;
        save_pos_reg <= save_pos_next;
        save_bit_reg <= save_bit_next;
        save_z1_reg  <= save_z1_next;
        zeros_reg    <= zeros_next;
        acc_reg      <= acc_next;
        value_reg    <= value_next;
        sval_reg     <= sval_next;
        rerr_reg     <= rerr_next;
        bl_reg       <= bl_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.do_append && !full)
        begin
            mem[count_reg[ADDR_W-1:0]] <= byte_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mem_rd)
        begin
            rd_data_reg <= mem[pos_reg[ADDR_W-1:0]];
        end
    end

    assign sts.cmd         = cmd_reg;
    assign sts.cnt_over    = (cnt_reg > MAX_GET);
    assign sts.at_end      = (pos_reg >= count_reg);
    assign sts.cur_valid   = cur_valid_reg;
    assign sts.loop_done   = !prefix_reg && (counter_reg == 16'd0);
    assign sts.esc_pending = esc_reg;

    assign value        = value_reg;
    assign signed_value = sval_reg;
    assign read_error   = rerr_reg;
    assign bits_left    = bl_reg;

    `NBR_ASSERT_ALWAYS(a_pos_le_count, clk, rst_n, pos_reg <= count_reg, "read position beyond byte count")
    `NBR_ASSERT_IMPL(a_cached_byte_written, clk, rst_n, cur_valid_reg, pos_reg < count_reg, "cached byte lies beyond byte count")
    `NBR_ASSERT_NEXT(a_escape_resolved, clk, rst_n, ctl.esc_chk, !esc_reg, "escape check left pending")

endmodule

/* design/nbr_ctrl.sv */
// Controller of the bit reader: sequences each request over the datapath.
`include "nal_bit_reader_exp_golomb_assert.svh"

module nbr_ctrl
    import nbr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output nbr_ctl_t ctl,
    input  nbr_sts_t sts
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_BIT    = 3'd2;
    localparam logic [2:0] S_ESCCHK = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        in_ready   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.load_req = 1'b1;
                    state_next   = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (sts.cmd)
                    CMD_APPEND:
                    begin
                        ctl.do_append = 1'b1;
                        state_next    = S_DONE;
                    end
                    CMD_NEWBUF:
                    begin
                        ctl.do_newbuf = 1'b1;
                        state_next    = S_DONE;
                    end
                    CMD_GET, CMD_SHOW:
                    begin
                        if (sts.cnt_over)
                        begin
                            // The start pulse still saves the position, so a show
                            // restores and reports the place it was issued at.
                            ctl.start   = 1'b1;
                            ctl.set_err = 1'b1;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            ctl.start  = 1'b1;
                            state_next = S_BIT;
                        end
                    end
                    CMD_SKIP, CMD_UE, CMD_SE:
                    begin
                        ctl.start  = 1'b1;
                        state_next = S_BIT;
                    end
                    default:
                    begin
                        // Unused command: no result.
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_BIT:
            begin
                if (sts.esc_pending)
                begin
                    ctl.mem_rd = 1'b1;
                    state_next = S_ESCCHK;
                end
                else if (sts.loop_done)
                begin
                    state_next = S_DONE;
                end
                else if (sts.at_end)
                begin
                    ctl.set_err = 1'b1;
                    state_next  = S_DONE;
                end
                else if (!sts.cur_valid)
                begin
                    ctl.mem_rd = 1'b1;
                end
                else
                begin
                    ctl.take_bit = 1'b1;
                end
            end
            S_ESCCHK:
            begin
                ctl.esc_chk = 1'b1;
                state_next  = S_BIT;
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    ctl.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `NBR_ASSERT_IMPL(a_take_has_byte, clk, rst_n, ctl.take_bit, sts.cur_valid && !sts.at_end, "bit taken without a loaded byte")
    `NBR_ASSERT_NEXT(a_finish_shows_result, clk, rst_n, ctl.finish, out_valid_reg, "result not presented after finish")
    `NBR_ASSERT_IMPL(a_finish_needs_slot, clk, rst_n, ctl.finish, slot_free, "result register overwritten while held")

endmodule

/* design/nal_bit_reader_exp_golomb.sv */
// Top level of the Exp-Golomb bitstream reader over one NAL payload.
//
// This block holds one NAL payload of up to BUF_BYTES (4096) bytes in an internal byte
// store, filled one byte per append request, and reads it most significant bit first,
// stepping over an emulation-prevention 0x03 that follows two zero bytes when the reader
// moves onto it. Requests are append byte, new buffer, get bits, show bits (no move),
// skip bits, and unsigned or signed Exp-Golomb decode; every request except the unused
// command code 7 returns exactly one result with the bits still unread. Append, new
// buffer and a get or show with a count above 32 reach the result without reading the
// store. Any other bit-reading request steps through its bits at one bit per cycle
// (prefix zeros, the terminating one and the suffix of a Golomb code all count),
// pausing each time a new byte is loaded through the store's registered read port;
// when the reader crosses onto a byte behind two zero bytes, the escape check loads
// that byte and tests it, and a skipped 0x03 is followed by one more load if reading
// goes on. A new request is accepted while the previous result still waits in the
// output register, but the block works on one request at a time. The byte store needs
// no clearing pass after reset: only bytes already written are ever read.
module nal_bit_reader_exp_golomb
    import nbr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    nbr_in_if.sink    in_ch,
    nbr_out_if.source out_ch
);

    nbr_ctl_t ctl;
    nbr_sts_t sts;

    // The controller owns the handshakes and walks each request through its steps.
    nbr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .ctl       (ctl),
        .sts       (sts)
    );

    // The datapath keeps the payload, the read position and the result register.
    nbr_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .sts          (sts),
        .command      (in_ch.command),
        .data_byte    (in_ch.data_byte),
        .bit_count    (in_ch.bit_count),
        .value        (out_ch.value),
        .signed_value (out_ch.signed_value),
        .read_error   (out_ch.read_error),
        .bits_left    (out_ch.bits_left)
    );

endmodule
